[hdl/grid_ray_caster_macros.svh]
// Assertion helpers shared by the ray caster RTL.
`ifndef GRID_RAY_CASTER_MACROS_SVH
`define GRID_RAY_CASTER_MACROS_SVH

// Same-cycle implication.
`define GRC_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GRC_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/grc_pkg.sv]
`timescale 1ns / 1ps

package grc_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int MAP_AW        = 6;
  localparam int CELL_AW       = 2 * MAP_AW;
  localparam int CELLS         = 1 << CELL_AW;
  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;

  localparam int DIV_NW = 2 * FRAC_BITS + 1;
  localparam int DIV_DW = 22;
  localparam int DELTA_W = DIV_NW + 1;
  localparam int SD_W    = 42;
  localparam int CFG_DW  = 22;
  localparam int CFG_AW  = 3;

  // camera offset: (col << 17) / SCREEN_WIDTH as (col * CAM_RECIP) >> CAM_SHIFT
  localparam int CAM_SHIFT = 13;
  localparam int CAM_KW    = 21;
  localparam int CAM_PW    = 10 + CAM_KW;

  localparam logic [DELTA_W-1:0] DELTA_CAP = DELTA_W'(1) << (2 * FRAC_BITS + 1);
  localparam logic [DIV_NW-1:0]  DELTA_NUM = DIV_NW'(1) << (2 * FRAC_BITS);
  localparam logic [DIV_NW-1:0]  LH_NUM    = DIV_NW'(SCREEN_HEIGHT) << FRAC_BITS;
  localparam logic [CAM_KW-1:0]  CAM_RECIP =
    CAM_KW'(((64'd1 << (FRAC_BITS + 1 + CAM_SHIFT)) + SCREEN_WIDTH - 1) / SCREEN_WIDTH);
  localparam logic [21:0]        PERP_MAX  = 22'h3FFFFF;
  localparam logic [14:0]        LH_MAX    = 15'h7FFF;
  localparam logic signed [16:0] HALF_H    = 17'(SCREEN_HEIGHT / 2);
  localparam logic signed [16:0] ROW_LO    = -17'sd16384;
  localparam logic signed [16:0] ROW_HI    = 17'sd16383;
  localparam logic signed [18:0] CAM_ONE   = 19'sd65536;

  typedef enum logic [CFG_AW-1:0] {
    CFG_PLAYER_X  = 3'd0,
    CFG_PLAYER_Y  = 3'd1,
    CFG_VIEW_X    = 3'd2,
    CFG_VIEW_Y    = 3'd3,
    CFG_PLANE_X   = 3'd4,
    CFG_PLANE_Y   = 3'd5
  } cfg_idx_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLR,
    OP_MAPWR,
    OP_LATCH,
    OP_CAM_GO,
    OP_CAM_SAVE,
    OP_DIR_MUL,
    OP_DIR_ADD,
    OP_DX_GO,
    OP_DX_SAVE,
    OP_DY_GO,
    OP_DY_SAVE,
    OP_SC_MUL,
    OP_SC_ADD,
    OP_STEP,
    OP_PERP,
    OP_TOT,
    OP_LH_GO,
    OP_LOAD_HIT,
    OP_LOAD_MISS
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic clr_last;
    logic cell_out;
    logic cell_wall;
    logic out_free;
  } dp_sts_t;

  typedef struct packed {
    logic       opcode;
    logic [9:0] column;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic       cell_wall;
  } in_word_t;

  typedef struct packed {
    logic [9:0]  column_out;
    logic        wall_hit;
    logic        hit_side;
    logic [5:0]  hit_cell_x;
    logic [5:0]  hit_cell_y;
    logic [21:0] perp_distance;
    logic [15:0] wall_fraction;
    logic [14:0] line_height;
    logic [14:0] draw_start;
    logic [14:0] draw_end;
  } out_word_t;

endpackage

[hdl/grc_if.sv]
`timescale 1ns / 1ps

interface grc_in_if;
  logic               valid;
  logic               ready;
  grc_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface grc_out_if;
  logic               valid;
  logic               ready;
  grc_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/grc_div.sv]
`timescale 1ns / 1ps

module grc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [grc_pkg::DIV_NW-1:0]  num,
  input  logic [grc_pkg::DIV_DW-1:0]  den,
  output logic                        done,
  output logic [grc_pkg::DIV_NW-1:0]  quot
);

  localparam int CW = $clog2(grc_pkg::DIV_NW);

  logic [grc_pkg::DIV_NW-1:0] q_r;
  logic [grc_pkg::DIV_DW-1:0] rem_r;
  logic [grc_pkg::DIV_DW-1:0] den_r;
  logic [CW-1:0]              cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [grc_pkg::DIV_DW:0]   sh_nxt;
  logic [grc_pkg::DIV_DW:0]   sub_nxt;
  logic                       ge_nxt;

  assign sh_nxt  = {rem_r, q_r[grc_pkg::DIV_NW-1]};
  assign ge_nxt  = sh_nxt >= {1'b0, den_r};
  assign sub_nxt = sh_nxt - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(grc_pkg::DIV_NW - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[grc_pkg::DIV_NW-2:0], ge_nxt};
      rem_r <= ge_nxt ? sub_nxt[grc_pkg::DIV_DW-1:0] : sh_nxt[grc_pkg::DIV_DW-1:0];
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

[hdl/grc_dpath.sv]
`timescale 1ns / 1ps
`include "grid_ray_caster_macros.svh"

module grc_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [grc_pkg::CFG_AW-1:0]  cfg_index,
  input  logic [grc_pkg::CFG_DW-1:0]  cfg_data,
  input  grc_pkg::in_word_t           in_word,
  input  grc_pkg::dp_cmd_t            cmd,
  output grc_pkg::dp_sts_t            sts,
  grc_out_if.source                   out_ch
);

  // configuration
  logic [21:0]        player_x_r, player_y_r;
  logic signed [17:0] view_x_r, view_y_r, plane_x_r, plane_y_r;

  // map store
  logic                        map_mem [grc_pkg::CELLS];
  logic [grc_pkg::CELL_AW-1:0] clr_cnt_r;
  logic                        rd_r;
  logic                        wr_en;
  logic [grc_pkg::CELL_AW-1:0] wr_addr;
  logic                        wr_bit;

  // ray state
  logic [9:0]                  col_r;
  logic [grc_pkg::CAM_PW-1:0]  cam_prod_r;
  logic signed [18:0]          cam_r;
  logic signed [36:0]          prx_r, pry_r;
  logic signed [21:0]          dx_r, dy_r;
  logic [grc_pkg::DELTA_W-1:0] ddx_r, ddy_r;
  logic [34:0]                 hx_r, hy_r;
  logic [32:0]                 lx_r, ly_r;
  logic [grc_pkg::SD_W-1:0]    sdx_r, sdy_r;
  logic [6:0]                  mx_r, my_r;
  logic                        side_r;
  logic [21:0]                 perp_r;
  logic [31:0]                 tot_r;

  // output register
  logic                 out_valid_r;
  grc_pkg::out_word_t   out_word_r;

  // divider
  logic                        div_start;
  logic [grc_pkg::DIV_NW-1:0]  div_num;
  logic [grc_pkg::DIV_DW-1:0]  div_den;
  logic                        div_done;
  logic [grc_pkg::DIV_NW-1:0]  div_quot;

  // combinational helpers
  logic [21:0]              adx, ady;
  logic [16:0]              fracx, fracy;
  logic                     step_x;
  logic [6:0]               mx_nxt, my_nxt;
  logic [grc_pkg::SD_W-1:0] diff_nxt;
  logic signed [21:0]       d_sel;
  logic [21:0]              p_sel;
  logic signed [44:0]       prod_nxt;
  logic [14:0]              lh_nxt;
  logic signed [16:0]       half_nxt, ls_nxt, le_nxt;
  logic [14:0]              ls_clip, le_clip;
  logic signed [18:0]       cam_nxt;

  grc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign adx = dx_r[21] ? 22'(-dx_r) : dx_r;
  assign ady = dy_r[21] ? 22'(-dy_r) : dy_r;

  always_comb begin
    div_start = 1'b0;
    div_num   = grc_pkg::DELTA_NUM;
    div_den   = adx;
    case (cmd.op)
      grc_pkg::OP_DX_GO: begin
        div_start = 1'b1;
      end
      grc_pkg::OP_DY_GO: begin
        div_start = 1'b1;
        div_den   = ady;
      end
      grc_pkg::OP_LH_GO: begin
        div_start = 1'b1;
        div_num   = grc_pkg::LH_NUM;
        div_den   = perp_r;
      end
      default: begin
      end
    endcase
  end

  // config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      player_x_r <= 22'd2097152;
      player_y_r <= 22'd2097152;
      view_x_r   <= 18'sd65536;
      view_y_r   <= '0;
      plane_x_r  <= '0;
      plane_y_r  <= 18'sd43254;
    end else if (cfg_we) begin
      case (grc_pkg::cfg_idx_t'(cfg_index))
        grc_pkg::CFG_PLAYER_X: player_x_r <= cfg_data;
        grc_pkg::CFG_PLAYER_Y: player_y_r <= cfg_data;
        grc_pkg::CFG_VIEW_X:   view_x_r   <= cfg_data[17:0];
        grc_pkg::CFG_VIEW_Y:   view_y_r   <= cfg_data[17:0];
        grc_pkg::CFG_PLANE_X:  plane_x_r  <= cfg_data[17:0];
        grc_pkg::CFG_PLANE_Y:  plane_y_r  <= cfg_data[17:0];
        default: begin
        end
      endcase
    end
  end

  // DDA step
  assign step_x = sdx_r < sdy_r;
  assign mx_nxt = step_x ? (mx_r + (dx_r[21] ? 7'h7F : 7'h01)) : mx_r;
  assign my_nxt = step_x ? my_r : (my_r + (dy_r[21] ? 7'h7F : 7'h01));

  // map memory
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_cnt_r;
    wr_bit  = 1'b0;
    if (cmd.op == grc_pkg::OP_CLR) begin
      wr_en = 1'b1;
    end else if (cmd.op == grc_pkg::OP_MAPWR) begin
      wr_en   = 1'b1;
      wr_addr = {in_word.cell_x, in_word.cell_y};
      wr_bit  = in_word.cell_wall;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_bit;
    end
    rd_r <= map_mem[{mx_nxt[grc_pkg::MAP_AW-1:0], my_nxt[grc_pkg::MAP_AW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.op == grc_pkg::OP_CLR) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign fracx = dx_r[21] ? {1'b0, player_x_r[15:0]} : 17'h10000 - {1'b0, player_x_r[15:0]};
  assign fracy = dy_r[21] ? {1'b0, player_y_r[15:0]} : 17'h10000 - {1'b0, player_y_r[15:0]};

  assign cam_nxt  = $signed({1'b0, cam_prod_r[grc_pkg::CAM_PW-1:grc_pkg::CAM_SHIFT]})
                    - grc_pkg::CAM_ONE;
  assign diff_nxt = side_r ? (sdy_r - grc_pkg::SD_W'(ddy_r)) : (sdx_r - grc_pkg::SD_W'(ddx_r));
  assign d_sel    = side_r ? dx_r : dy_r;
  assign p_sel    = side_r ? player_x_r : player_y_r;
  assign prod_nxt = $signed({1'b0, perp_r}) * d_sel;

  assign lh_nxt   = (|div_quot[grc_pkg::DIV_NW-1:15]) ? grc_pkg::LH_MAX : div_quot[14:0];
  assign half_nxt = $signed({3'b0, lh_nxt[14:1]});
  assign ls_nxt   = grc_pkg::HALF_H - half_nxt;
  assign le_nxt   = grc_pkg::HALF_H + half_nxt;
  assign ls_clip  = (ls_nxt < grc_pkg::ROW_LO) ? grc_pkg::ROW_LO[14:0] :
                    (ls_nxt > grc_pkg::ROW_HI) ? grc_pkg::ROW_HI[14:0] : ls_nxt[14:0];
  assign le_clip  = (le_nxt < grc_pkg::ROW_LO) ? grc_pkg::ROW_LO[14:0] :
                    (le_nxt > grc_pkg::ROW_HI) ? grc_pkg::ROW_HI[14:0] : le_nxt[14:0];

  always_ff @(posedge clk) begin
    case (cmd.op)
      grc_pkg::OP_LATCH:    col_r <= in_word.column;
      grc_pkg::OP_CAM_GO:   cam_prod_r <= col_r * grc_pkg::CAM_RECIP;
      grc_pkg::OP_CAM_SAVE: cam_r <= cam_nxt;
      grc_pkg::OP_DIR_MUL: begin
        prx_r <= plane_x_r * cam_r;
        pry_r <= plane_y_r * cam_r;
      end
      grc_pkg::OP_DIR_ADD: begin
        dx_r <= {{4{view_x_r[17]}}, view_x_r} + {prx_r[36], prx_r[36:16]};
        dy_r <= {{4{view_y_r[17]}}, view_y_r} + {pry_r[36], pry_r[36:16]};
      end
      grc_pkg::OP_DX_SAVE:
        ddx_r <= (dx_r == '0) ? grc_pkg::DELTA_CAP : {1'b0, div_quot};
      grc_pkg::OP_DY_SAVE:
        ddy_r <= (dy_r == '0) ? grc_pkg::DELTA_CAP : {1'b0, div_quot};
      grc_pkg::OP_SC_MUL: begin
        hx_r   <= ddx_r[grc_pkg::DELTA_W-1:16] * fracx;
        lx_r   <= ddx_r[15:0] * fracx;
        hy_r   <= ddy_r[grc_pkg::DELTA_W-1:16] * fracy;
        ly_r   <= ddy_r[15:0] * fracy;
        mx_r   <= {1'b0, player_x_r[21:16]};
        my_r   <= {1'b0, player_y_r[21:16]};
        side_r <= 1'b0;
      end
      grc_pkg::OP_SC_ADD: begin
        sdx_r <= grc_pkg::SD_W'(hx_r) + grc_pkg::SD_W'(lx_r[32:16]);
        sdy_r <= grc_pkg::SD_W'(hy_r) + grc_pkg::SD_W'(ly_r[32:16]);
      end
      grc_pkg::OP_STEP: begin
        mx_r   <= mx_nxt;
        my_r   <= my_nxt;
        side_r <= !step_x;
        if (step_x) begin
          sdx_r <= sdx_r + grc_pkg::SD_W'(ddx_r);
        end else begin
          sdy_r <= sdy_r + grc_pkg::SD_W'(ddy_r);
        end
      end
      grc_pkg::OP_PERP:
        perp_r <= (diff_nxt > grc_pkg::SD_W'(grc_pkg::PERP_MAX)) ? grc_pkg::PERP_MAX
                                                                 : diff_nxt[21:0];
      grc_pkg::OP_TOT:
        tot_r <= {p_sel[15:0], 16'b0} + prod_nxt[31:0];
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == grc_pkg::OP_LOAD_HIT || cmd.op == grc_pkg::OP_LOAD_MISS) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == grc_pkg::OP_LOAD_HIT) begin
      out_word_r.column_out    <= col_r;
      out_word_r.wall_hit      <= 1'b1;
      out_word_r.hit_side      <= side_r;
      out_word_r.hit_cell_x    <= mx_r[5:0];
      out_word_r.hit_cell_y    <= my_r[5:0];
      out_word_r.perp_distance <= perp_r;
      out_word_r.wall_fraction <= tot_r[31:16];
      out_word_r.line_height   <= lh_nxt;
      out_word_r.draw_start    <= ls_clip;
      out_word_r.draw_end      <= le_clip;
    end else if (cmd.op == grc_pkg::OP_LOAD_MISS) begin
      out_word_r            <= '0;
      out_word_r.column_out <= col_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  assign sts.div_done  = div_done;
  assign sts.clr_last  = &clr_cnt_r;
  assign sts.cell_out  = mx_r[6] | my_r[6];
  assign sts.cell_wall = rd_r;
  assign sts.out_free  = !out_valid_r || out_ch.ready;

  `GRC_ASSERT_NXT(a_load_fills, clk, rst_n, cmd.op == grc_pkg::OP_LOAD_HIT || cmd.op == grc_pkg::OP_LOAD_MISS, out_valid_r, "result load did not fill output register")
  `GRC_ASSERT_IMP(a_miss_zero, clk, rst_n, out_valid_r && !out_word_r.wall_hit, out_word_r.perp_distance == '0 && out_word_r.line_height == '0, "miss result carries nonzero fields")
  `GRC_ASSERT_IMP(a_step_in_map, clk, rst_n, cmd.op == grc_pkg::OP_STEP, !(mx_r[6] || my_r[6]), "grid step taken from outside the map")

endmodule

[hdl/grc_ctrl.sv]
`timescale 1ns / 1ps
`include "grid_ray_caster_macros.svh"

module grc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_cast,
  output logic              in_ready,
  output grc_pkg::dp_cmd_t  cmd,
  input  grc_pkg::dp_sts_t  sts
);

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CAM,
    ST_CAM_W,
    ST_DIR_MUL,
    ST_DIR_ADD,
    ST_DX,
    ST_DX_W,
    ST_DY,
    ST_DY_W,
    ST_SC_MUL,
    ST_SC_ADD,
    ST_STEP,
    ST_CHECK,
    ST_PERP,
    ST_TOT,
    ST_LH,
    ST_LH_W,
    ST_FIN,
    ST_MISS
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = grc_pkg::OP_NOP;
    case (state_r)
      ST_CLEAR: begin
        cmd.op = grc_pkg::OP_CLR;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cast) begin
            cmd.op    = grc_pkg::OP_LATCH;
            state_nxt = ST_CAM;
          end else begin
            cmd.op = grc_pkg::OP_MAPWR;
          end
        end
      end
      ST_CAM: begin
        cmd.op    = grc_pkg::OP_CAM_GO;
        state_nxt = ST_CAM_W;
      end
      ST_CAM_W: begin
        cmd.op    = grc_pkg::OP_CAM_SAVE;
        state_nxt = ST_DIR_MUL;
      end
      ST_DIR_MUL: begin
        cmd.op    = grc_pkg::OP_DIR_MUL;
        state_nxt = ST_DIR_ADD;
      end
      ST_DIR_ADD: begin
        cmd.op    = grc_pkg::OP_DIR_ADD;
        state_nxt = ST_DX;
      end
      ST_DX: begin
        cmd.op    = grc_pkg::OP_DX_GO;
        state_nxt = ST_DX_W;
      end
      ST_DX_W: begin
        if (sts.div_done) begin
          cmd.op    = grc_pkg::OP_DX_SAVE;
          state_nxt = ST_DY;
        end
      end
      ST_DY: begin
        cmd.op    = grc_pkg::OP_DY_GO;
        state_nxt = ST_DY_W;
      end
      ST_DY_W: begin
        if (sts.div_done) begin
          cmd.op    = grc_pkg::OP_DY_SAVE;
          state_nxt = ST_SC_MUL;
        end
      end
      ST_SC_MUL: begin
        cmd.op    = grc_pkg::OP_SC_MUL;
        state_nxt = ST_SC_ADD;
      end
      ST_SC_ADD: begin
        cmd.op    = grc_pkg::OP_SC_ADD;
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        cmd.op    = grc_pkg::OP_STEP;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.cell_out)       state_nxt = ST_MISS;
        else if (sts.cell_wall) state_nxt = ST_PERP;
        else                    state_nxt = ST_STEP;
      end
      ST_PERP: begin
        cmd.op    = grc_pkg::OP_PERP;
        state_nxt = ST_TOT;
      end
      ST_TOT: begin
        cmd.op    = grc_pkg::OP_TOT;
        state_nxt = ST_LH;
      end
      ST_LH: begin
        cmd.op    = grc_pkg::OP_LH_GO;
        state_nxt = ST_LH_W;
      end
      ST_LH_W: begin
        if (sts.div_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.op    = grc_pkg::OP_LOAD_HIT;
          state_nxt = ST_IDLE;
        end
      end
      ST_MISS: begin
        if (sts.out_free) begin
          cmd.op    = grc_pkg::OP_LOAD_MISS;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  `GRC_ASSERT_IMP(a_done_in_wait, clk, rst_n, sts.div_done, state_r == ST_DX_W || state_r == ST_DY_W || state_r == ST_LH_W, "divider finished outside a wait state")

endmodule

[hdl/grid_ray_caster.sv]
`timescale 1ns / 1ps

// DDA ray caster over a 64 x 64 one-bit wall map. A map write word is taken
// without leaving the idle state. A cast word runs three divisions on one shared
// radix-2 divider (both ray deltas, line height); the camera offset comes from
// a reciprocal multiply. Setup arithmetic comes first, then a walk loop of a
// step state and a check state per grid cell crossed, the check state using the
// registered map read. After reset the map is cleared one cell per cycle, all
// 4096 cells, during which no word is taken; configuration writes are taken at
// any time and must only change while the block is idle. A finished result
// waits in an output register while the next word is taken.
module grid_ray_caster (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [grc_pkg::CFG_AW-1:0]  cfg_index,
  input  logic [grc_pkg::CFG_DW-1:0]  cfg_data,
  grc_in_if.sink                      in_ch,
  grc_out_if.source                   out_ch
);

  grc_pkg::dp_cmd_t cmd;
  grc_pkg::dp_sts_t sts;

  grc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cast  (in_ch.data.opcode),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  grc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_ch.data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ch    (out_ch)
  );

endmodule

[tb/sv/grc_checker.sv]
`timescale 1ns / 1ps

module grc_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [grc_pkg::CFG_AW-1:0] cfg_index,
  input  logic [grc_pkg::CFG_DW-1:0] cfg_data,
  grc_in_if                          in_ch,
  grc_out_if                         out_ch,
  output int                         fail_count,
  output int                         pending,
  output int                         result_count,
  output int                         hit_count
);

  localparam longint ONE_Q = 64'sd65536;
  localparam longint CAP_Q = 64'sd1 << 33;

  bit                  wall_map [grc_pkg::CELLS];
  logic [21:0]         pos_x, pos_y;
  logic signed [17:0]  dir_x, dir_y, plane_x, plane_y;
  grc_pkg::out_word_t  expected_q[$];

  assign pending = expected_q.size();

  function automatic longint ray_delta(longint d);
    longint m, q;
    if (d == 0) return CAP_Q;
    m = (d < 0) ? -d : d;
    q = (64'sd1 <<< 32) / m;
    return (q > CAP_Q) ? CAP_Q : q;
  endfunction

  function automatic longint scale(longint frac, longint delta);
    return (delta >>> 16) * frac + (((delta & 64'hFFFF) * frac) >>> 16);
  endfunction

  function automatic grc_pkg::out_word_t cast_ray(logic [9:0] col);
    grc_pkg::out_word_t r;
    longint cam, dx, dy, ddx, ddy, sdx, sdy, fx, fy, mx, my, sx, sy;
    longint perp, total, lh, ls, le;
    bit side, hit;
    r = '0;
    r.column_out = col;
    side = 0;
    hit = 0;
    cam = ((longint'(col) * 2) <<< 16) / grc_pkg::SCREEN_WIDTH - ONE_Q;
    dx = longint'(dir_x) + ((longint'(plane_x) * cam) >>> 16);
    dy = longint'(dir_y) + ((longint'(plane_y) * cam) >>> 16);
    ddx = ray_delta(dx);
    ddy = ray_delta(dy);
    mx = longint'(pos_x) >>> 16;
    my = longint'(pos_y) >>> 16;
    fx = longint'(pos_x) & 64'hFFFF;
    fy = longint'(pos_y) & 64'hFFFF;
    if (dx < 0) begin sx = -1; sdx = scale(fx, ddx); end
    else begin sx = 1; sdx = scale(ONE_Q - fx, ddx); end
    if (dy < 0) begin sy = -1; sdy = scale(fy, ddy); end
    else begin sy = 1; sdy = scale(ONE_Q - fy, ddy); end
    while (mx >= 0 && mx < 64 && my >= 0 && my < 64) begin
      if (sdx < sdy) begin
        sdx += ddx; mx += sx; side = 0;
      end else begin
        sdy += ddy; my += sy; side = 1;
      end
      if (!(mx >= 0 && mx < 64 && my >= 0 && my < 64)) break;
      if (wall_map[mx * 64 + my]) begin
        hit = 1;
        break;
      end
    end
    if (!hit) return r;
    perp = side ? sdy - ddy : sdx - ddx;
    if (perp > 64'sd4194303) perp = 64'sd4194303;
    if (side) total = longint'(pos_x) * ONE_Q + perp * dx;
    else total = longint'(pos_y) * ONE_Q + perp * dy;
    if (perp == 0) lh = 32767;
    else begin
      lh = (longint'(grc_pkg::SCREEN_HEIGHT) <<< 16) / perp;
      if (lh > 32767) lh = 32767;
    end
    ls = grc_pkg::SCREEN_HEIGHT / 2 - lh / 2;
    le = grc_pkg::SCREEN_HEIGHT / 2 + lh / 2;
    if (ls < -16384) ls = -16384;
    if (ls > 16383) ls = 16383;
    if (le < -16384) le = -16384;
    if (le > 16383) le = 16383;
    r.wall_hit = 1;
    r.hit_side = side;
    r.hit_cell_x = mx[5:0];
    r.hit_cell_y = my[5:0];
    r.perp_distance = perp[21:0];
    r.wall_fraction = total[31:16];
    r.line_height = lh[14:0];
    r.draw_start = ls[14:0];
    r.draw_end = le[14:0];
    return r;
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    grc_pkg::out_word_t e, a;
    if (!rst_n) begin
      foreach (wall_map[i]) wall_map[i] = 0;
      pos_x = 22'd2097152;
      pos_y = 22'd2097152;
      dir_x = 18'sd65536;
      dir_y = 18'sd0;
      plane_x = 18'sd0;
      plane_y = 18'sd43254;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          grc_pkg::CFG_PLAYER_X: pos_x = cfg_data;
          grc_pkg::CFG_PLAYER_Y: pos_y = cfg_data;
          grc_pkg::CFG_VIEW_X:   dir_x = cfg_data[17:0];
          grc_pkg::CFG_VIEW_Y:   dir_y = cfg_data[17:0];
          grc_pkg::CFG_PLANE_X:  plane_x = cfg_data[17:0];
          grc_pkg::CFG_PLANE_Y:  plane_y = cfg_data[17:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.data.opcode) expected_q.push_back(cast_ray(in_ch.data.column));
        else wall_map[{in_ch.data.cell_x, in_ch.data.cell_y}] = in_ch.data.cell_wall;
      end
      if (out_ch.valid && out_ch.ready) begin
        a = out_ch.data;
        result_count++;
        if (a.wall_hit) hit_count++;
        if (expected_q.size() == 0) begin
          $error("unexpected result word for column %0d", a.column_out);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          check_field("column_out", e.column_out, a.column_out);
          check_field("wall_hit", e.wall_hit, a.wall_hit);
          check_field("hit_side", e.hit_side, a.hit_side);
          check_field("hit_cell_x", e.hit_cell_x, a.hit_cell_x);
          check_field("hit_cell_y", e.hit_cell_y, a.hit_cell_y);
          check_field("perp_distance", e.perp_distance, a.perp_distance);
          check_field("wall_fraction", e.wall_fraction, a.wall_fraction);
          check_field("line_height", e.line_height, a.line_height);
          check_field("draw_start", $signed(e.draw_start), $signed(a.draw_start));
          check_field("draw_end", $signed(e.draw_end), $signed(a.draw_end));
        end
      end
    end
  end

  initial begin
    fail_count = 0;
    result_count = 0;
    hit_count = 0;
  end
endmodule

[tb/sv/tb_grid_ray_caster.sv]
`timescale 1ns / 1ps

module tb_grid_ray_caster;

  localparam logic [grc_pkg::CFG_AW-1:0] CFG_SPARE = 3'd7;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;
  localparam int   STALL_LIMIT = 20000;

  logic                       clk = 0;
  logic                       rst_n = 0;
  logic                       cfg_we = 0;
  logic [grc_pkg::CFG_AW-1:0] cfg_index = '0;
  logic [grc_pkg::CFG_DW-1:0] cfg_data = '0;
  int                fail_count, pending, result_count, hit_count;
  int                words_in = 0;
  bit                quiet = 0;
  int                hold_req = 0, hold_ack = 0, hold_left = 0, gap_left = 0;
  int                idle_cycles = 0;

  grc_in_if  in_ch ();
  grc_out_if out_ch ();

  grid_ray_caster dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  grc_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending(pending),
    .result_count(result_count), .hit_count(hit_count)
  );

  always #4 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
  end

  // result-side backpressure
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= 400;
      out_ch.ready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 0;
    end else if (quiet) begin
      out_ch.ready <= 1;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      out_ch.ready <= 0;
    end else if ($urandom_range(0, 5) == 0) begin
      gap_left <= $urandom_range(0, 4);
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= 1;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send(logic op, logic [9:0] col, logic [5:0] cx, logic [5:0] cy,
                      logic wall);
    grc_pkg::in_word_t w;
    w = '{opcode: op, column: col, cell_x: cx, cell_y: cy, cell_wall: wall};
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_in++;
  endtask

  task automatic cast(logic [9:0] col);
    send(OP_CAST, col, 6'($urandom), 6'($urandom), 1'($urandom));
  endtask

  task automatic put_cell(logic [5:0] cx, logic [5:0] cy, logic wall);
    send(OP_WRITE, 10'($urandom), cx, cy, wall);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(logic [grc_pkg::CFG_AW-1:0] idx,
                           logic [grc_pkg::CFG_DW-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_view(logic [21:0] px, logic [21:0] py, logic [17:0] vx,
                          logic [17:0] vy, logic [17:0] cx, logic [17:0] cy);
    cfg_write(grc_pkg::CFG_PLAYER_X, px);
    cfg_write(grc_pkg::CFG_PLAYER_Y, py);
    cfg_write(grc_pkg::CFG_VIEW_X, 22'(vx));
    cfg_write(grc_pkg::CFG_VIEW_Y, 22'(vy));
    cfg_write(grc_pkg::CFG_PLANE_X, 22'(cx));
    cfg_write(grc_pkg::CFG_PLANE_Y, 22'(cy));
    @(posedge clk);
  endtask

  task automatic random_words(int n);
    logic [5:0] cx, cy;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 3) begin
        if ($urandom_range(0, 1)) begin
          cx = 6'(32 + $urandom_range(0, 16) - 8);
          cy = 6'(32 + $urandom_range(0, 16) - 8);
        end else begin
          cx = 6'($urandom);
          cy = 6'($urandom);
        end
        put_cell(cx, cy, $urandom_range(0, 3) != 0);
      end else begin
        cast(10'($urandom_range(0, 1023)));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    cfg_write(CFG_SPARE, '1);

    // directed: wall ahead, start cell, corners, column extremes
    put_cell(6'd33, 6'd32, 1);
    put_cell(6'd32, 6'd32, 1);
    put_cell(6'd63, 6'd63, 1);
    put_cell(6'd0, 6'd0, 0);
    put_cell(6'd40, 6'd40, 1);
    cast(10'd0);
    cast(10'd320);
    cast(10'd639);
    cast(10'd640);
    cast(10'd1023);
    drain();
    set_view(22'd2129920, 22'd2097152, 18'sd0, 18'sd0, 18'sd0, 18'sd0);
    cast(10'd0);
    cast(10'd320);
    drain();
    set_view(22'd0, 22'd0, 18'sd131071, 18'sd131071, -18'sd131072, 18'sd131071);
    put_cell(6'd1, 6'd1, 1);
    cast(10'd0);
    cast(10'd511);
    cast(10'd1023);
    drain();
    set_view(22'h3FFFFF, 22'h3FFFFF, -18'sd131072, -18'sd131072, 18'sd131071,
             -18'sd131072);
    put_cell(6'd62, 6'd62, 1);
    cast(10'd0);
    cast(10'd320);
    cast(10'd1023);
    drain();

    set_view(22'd2097152, 22'd2097152, 18'sd65536, 18'sd0, 18'sd0, 18'sd43254);
    random_words(110);
    hold_req <= 1;
    random_words(30);
    drain();
    for (int p = 0; p < 4; p++) begin
      set_view(22'($urandom_range(8 << 16, 56 << 16)),
               22'($urandom_range(8 << 16, 56 << 16)),
               18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom));
      random_words(120);
      drain();
    end
    quiet = 1;
    set_view(22'($urandom), 22'($urandom), 18'($urandom), 18'($urandom),
             18'($urandom), 18'($urandom));
    random_words(80);
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (500) @(posedge clk);

    $display("sent %0d words; checked %0d results, %0d of them wall hits",
             words_in, result_count, hit_count);
    $display("views: default, zero direction, both corners, five random poses");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+hdl
hdl/grc_pkg.sv
hdl/grc_if.sv
hdl/grc_div.sv
hdl/grc_dpath.sv
hdl/grc_ctrl.sv
hdl/grid_ray_caster.sv
tb/sv/grc_checker.sv
tb/sv/tb_grid_ray_caster.sv
